FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the debouncer RTL.
// No dependencies; take in with `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and muted while rst is high.
`define AST_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and muted while rst is high.
`define AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mkrd_pkg.sv
// Types, constants and helpers for the multi-key release debouncer.
// No dependencies.
package mkrd_pkg;

  localparam int NUM_KEYS_DEF = 4;
  localparam int PIN_W        = 4;
  localparam int TICK_W       = 10;
  localparam int KEY_IDX_W    = 2;
  localparam int CFG_IDX_W    = 2;

  localparam logic [TICK_W-1:0] DEBOUNCE_RST = TICK_W'(50);
  localparam logic [TICK_W-1:0] RECHECK_RST  = TICK_W'(10);

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RECHECK  = CFG_IDX_W'(1);

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  // Per-lane status handed to the merge stage and the top level.
  typedef struct packed {
    logic fire;   // countdown ran out with the pin released
    logic busy;   // countdown running
    logic armed;  // key waiting for a falling edge
  } lane_status_t;

  typedef struct packed {
    logic                 event_valid;
    logic [KEY_IDX_W-1:0] key_index;
    logic                 event_pending;
  } result_t;

  // A zero tick count behaves as one.
  function automatic logic [TICK_W-1:0] load_value(input logic [TICK_W-1:0] r);
    return (r == '0) ? TICK_W'(1) : r;
  endfunction

endpackage

FILE: rtl/core/mkrd_if.sv
// Channel interfaces of the debouncer: input items, result items, config writes.
// Depends on mkrd_pkg.
interface mkrd_item_if import mkrd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [PIN_W-1:0] key_levels;
  modport source (output valid, action, key_levels, input ready);
  modport sink   (input valid, action, key_levels, output ready);
endinterface

interface mkrd_result_if import mkrd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 event_valid;
  logic [KEY_IDX_W-1:0] key_index;
  logic                 event_pending;
  modport source (output valid, event_valid, key_index, event_pending, input ready);
  modport sink   (input valid, event_valid, key_index, event_pending, output ready);
endinterface

interface mkrd_cfg_if import mkrd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TICK_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/multi_key_release_debouncer_unit.sv
// Multi-key release debouncer, top level. Depends on mkrd_pkg, mkrd_if, mkrd_lane,
// mkrd_merge and assert_macros.svh.
// Each result item is registered from its input item in the output stage. Throughput: one item
// per cycle while in_item.ready is high; a two-entry output stage absorbs stalls.
// Reset (rst, synchronous): keys armed, timers stopped, no event, ticks 50/10.
`include "assert_macros.svh"
module multi_key_release_debouncer_unit import mkrd_pkg::*; #(
  parameter int NUM_KEYS_P = NUM_KEYS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  mkrd_item_if.sink     in_item,
  mkrd_result_if.source out_result,
  mkrd_cfg_if.sink      cfg
);

  // ---------------------------------------------------------------------------
  // Configuration registers; writes to unknown indexes are dropped.
  // ---------------------------------------------------------------------------
  logic [TICK_W-1:0] debounce_ticks;
  logic [TICK_W-1:0] recheck_ticks;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RST;
      recheck_ticks  <= RECHECK_RST;
    end else if (cfg.valid) begin
      if (cfg.index == REG_DEBOUNCE) begin
        debounce_ticks <= cfg.data;
      end else if (cfg.index == REG_RECHECK) begin
        recheck_ticks <= cfg.data;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input acceptance. Ready only drops when both output slots are full.
  // ---------------------------------------------------------------------------
  logic in_acc, tick, read;
  logic skid_valid, res_valid;

  assign in_item.ready = !skid_valid;
  assign in_acc        = in_item.valid && in_item.ready;
  assign tick          = in_acc && (in_item.action == ACT_TICK);
  assign read          = in_acc && (in_item.action == ACT_READ);

  // Pin history: updated only on tick items.
  logic [PIN_W-1:0] prev_levels;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_levels <= '1;
    end else if (tick) begin
      prev_levels <= in_item.key_levels;
    end
  end

  // ---------------------------------------------------------------------------
  // Key lanes, one per key. Keys beyond the pin word see a low pin.
  // ---------------------------------------------------------------------------
  logic [TICK_W-1:0] debounce_load, recheck_load;
  assign debounce_load = load_value(debounce_ticks);
  assign recheck_load  = load_value(recheck_ticks);

  lane_status_t          lane_st [NUM_KEYS_P];
  logic [NUM_KEYS_P-1:0] fire_vec, busy_vec, armed_vec;

  for (genvar i = 0; i < NUM_KEYS_P; i++) begin : g_lane
    logic now, prev_pin;
    if (i < PIN_W) begin : g_pin
      assign now      = in_item.key_levels[i];
      assign prev_pin = prev_levels[i];
    end else begin : g_nopin
      assign now      = 1'b0;
      assign prev_pin = 1'b0;
    end

    mkrd_lane u_lane (
      .clk           (clk),
      .rst           (rst),
      .tick          (tick),
      .now           (now),
      .prev_pin      (prev_pin),
      .debounce_load (debounce_load),
      .recheck_load  (recheck_load),
      .status        (lane_st[i])
    );

    assign fire_vec[i]  = lane_st[i].fire;
    assign busy_vec[i]  = lane_st[i].busy;
    assign armed_vec[i] = lane_st[i].armed;
  end

  // ---------------------------------------------------------------------------
  // Merge and one-entry event latch.
  // ---------------------------------------------------------------------------
  logic                 pending_flag, pending_next;
  logic [KEY_IDX_W-1:0] latched_key, latched_next;
  result_t              step_res;

  mkrd_merge #(
    .NUM_KEYS_P (NUM_KEYS_P)
  ) u_merge (
    .fire         (fire_vec),
    .read         (read),
    .pending      (pending_flag),
    .latched      (latched_key),
    .pending_next (pending_next),
    .latched_next (latched_next),
    .result       (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_flag <= 1'b0;
      latched_key  <= '0;
    end else if (in_acc) begin
      pending_flag <= pending_next;
      latched_key  <= latched_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register plus skid slot.
  // ---------------------------------------------------------------------------
  result_t res_q, skid_q;
  logic    out_pop;

  assign out_pop = res_valid && out_result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_pop) begin
        skid_valid <= 1'b0;
      end
    end else if (in_acc) begin
      if (res_valid && !out_pop) begin
        skid_valid <= 1'b1;
      end else begin
        res_valid <= 1'b1;
      end
    end else if (out_pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_pop) begin
        res_q <= skid_q;
      end
    end else if (in_acc) begin
      if (res_valid && !out_pop) begin
        skid_q <= step_res;
      end else begin
        res_q <= step_res;
      end
    end
  end

  assign out_result.valid         = res_valid;
  assign out_result.event_valid   = res_q.event_valid;
  assign out_result.key_index     = res_q.key_index;
  assign out_result.event_pending = res_q.event_pending;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `AST_IMPL(a_busy_disarmed, 1'b1, (busy_vec & armed_vec) == '0, "running timer on armed key")
  `AST_IMPL(a_skid_order, skid_valid, res_valid, "skid slot filled ahead of output")
  `AST_NEXT(a_read_clears, read, !pending_flag, "event not cleared by read")
  `AST_NEXT(a_fire_latches, tick && (fire_vec != '0), pending_flag, "release not latched")

endmodule

FILE: rtl/core/mkrd_lane.sv
// One key lane: arm flag and countdown timer.
// Depends on mkrd_pkg.
module mkrd_lane import mkrd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick,
  input  logic              now,
  input  logic              prev_pin,
  input  logic [TICK_W-1:0] debounce_load,
  input  logic [TICK_W-1:0] recheck_load,
  output lane_status_t      status
);

  logic              armed, armed_next;
  logic [TICK_W-1:0] count, count_next;
  logic [TICK_W-1:0] count_dec;
  logic              fire;

  assign count_dec = count - TICK_W'(1);

  always_comb begin
    armed_next = armed;
    count_next = count;
    fire       = 1'b0;
    if (tick) begin
      if (count != '0) begin
        count_next = count_dec;
        if (count_dec == '0) begin
          if (now) begin
            fire       = 1'b1;
            armed_next = 1'b1;
          end else begin
            count_next = recheck_load;
          end
        end
      end else if (armed && prev_pin && !now) begin
        armed_next = 1'b0;
        count_next = debounce_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b1;
      count <= '0;
    end else begin
      armed <= armed_next;
      count <= count_next;
    end
  end

  assign status.fire  = fire;
  assign status.busy  = (count != '0);
  assign status.armed = armed;

endmodule

FILE: rtl/core/mkrd_merge.sv
// Merge stage: picks the highest firing lane and forms the result and event latch.
// Depends on mkrd_pkg.
module mkrd_merge import mkrd_pkg::*; #(
  parameter int NUM_KEYS_P = NUM_KEYS_DEF
) (
  input  logic [NUM_KEYS_P-1:0] fire,
  input  logic                  read,
  input  logic                  pending,
  input  logic [KEY_IDX_W-1:0]  latched,
  output logic                  pending_next,
  output logic [KEY_IDX_W-1:0]  latched_next,
  output result_t               result
);

  logic                 hit;
  logic [KEY_IDX_W-1:0] hit_idx;

  // Highest index wins a tie: later lanes override.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < NUM_KEYS_P; i++) begin
      if (fire[i]) begin
        hit     = 1'b1;
        hit_idx = KEY_IDX_W'(i);
      end
    end
  end

  always_comb begin
    pending_next = pending;
    latched_next = latched;
    if (read) begin
      pending_next = 1'b0;
    end else if (hit) begin
      pending_next = 1'b1;
      latched_next = hit_idx;
    end
  end

  assign result.event_valid   = read && pending;
  assign result.key_index     = latched_next;
  assign result.event_pending = pending_next;

endmodule
